>>> hw/rtl/hitc_pkg.sv
// hitc_pkg: shared types, character codes and entity tables of the text cleaner
// no dependencies; imported by the controller, datapath and top level
package hitc_pkg;

  localparam int HOLD_DEPTH  = 5;  // bytes held after an '&'
  localparam int NUM_ENT     = 7;
  localparam int QUEUE_DEPTH = 5;  // work queue: input byte plus replayed bytes
  localparam int CAP_W       = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd128;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_VT    = 8'h0b;
  localparam logic [7:0] CHAR_FF    = 8'h0c;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_LT    = 8'h3c;
  localparam logic [7:0] CHAR_GT    = 8'h3e;

  // entity names after the '&', unused tail bytes zero
  localparam logic [7:0] ENT_NAME [NUM_ENT][HOLD_DEPTH] = '{
    '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // amp;
    '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // lt;
    '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // gt;
    '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},  // quot;
    '{8'h23, 8'h33, 8'h39, 8'h3b, 8'h00},  // #39;
    '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},  // apos;
    '{8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b}   // nbsp;
  };
  localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd4, 3'd5, 3'd5};
  // decoded character, zero means whitespace
  localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{
    8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h27, 8'h00
  };

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic load;   // take the input beat into the work queue
    logic step;   // one datapath action
    logic flush;  // close the item: staged beat leaves marked last
  } dp_cmd_t;

  typedef struct packed {
    logic busy;      // work left for the current item
    logic out_free;  // output register can take a beat this cycle
  } dp_status_t;

endpackage

>>> hw/rtl/hitc_if.sv
// hitc_if: valid/ready channel interfaces for raw text beats and cleaned beats
// no dependencies
interface hitc_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

interface hitc_clean_if;
  logic       valid;
  logic       ready;
  logic [7:0] clean_byte;
  logic       is_char;
  logic       run_last;

  modport source (output valid, output clean_byte, output is_char, output run_last,
                  input ready);
  modport sink (input valid, input clean_byte, input is_char, input run_last,
                output ready);
endinterface

>>> hw/rtl/hitc_ctrl.sv
// hitc_ctrl: controller state machine sequencing load, step and flush
// depends on hitc_pkg
module hitc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hitc_pkg::dp_status_t status,
  output hitc_pkg::dp_cmd_t    cmd
);
  import hitc_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        closing;

  assign closing = (state == ST_RUN) && !status.busy && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (closing && !in_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        // next item may enter in the cycle that closes this one
        in_ready  = closing;
        cmd.load  = closing && in_valid;
        cmd.flush = closing;
        cmd.step  = status.busy && status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/hitc_datapath.sv
// hitc_datapath: work queue, entity lookahead, text state, staging and output registers
// depends on hitc_pkg
module hitc_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  hitc_pkg::dp_cmd_t          cmd,
  output hitc_pkg::dp_status_t       status,
  input  logic [7:0]                in_byte,
  input  logic                      in_end,
  input  logic                      cfg_wr_en,
  input  logic [hitc_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [7:0]                out_byte,
  output logic                      out_char,
  output logic                      out_last
);
  import hitc_pkg::*;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
           (c == CHAR_CR) || (c == CHAR_FF) || (c == CHAR_VT);
  endfunction

  logic [CAP_W-1:0] cap;
  logic             inside_tag, inside_tag_next;
  logic             space_owed, space_owed_next;
  logic [CAP_W-1:0] count, count_next;
  logic             pending, pending_next;
  logic [7:0]       la [HOLD_DEPTH];
  logic [7:0]       la_next [HOLD_DEPTH];
  logic [2:0]       fill, fill_next;
  logic [7:0]       q [QUEUE_DEPTH];
  logic [7:0]       q_next [QUEUE_DEPTH];
  logic [2:0]       qcnt, qcnt_next;
  logic             end_flag, end_flag_next;
  logic             char_due, char_due_next;
  logic [7:0]       char_hold, char_hold_next;
  logic             stg_valid, stg_valid_next;
  logic [7:0]       stg_byte, stg_byte_next;
  logic             stg_char, stg_char_next;
  logic             out_valid_next;
  logic [7:0]       out_byte_next;
  logic             out_char_next;
  logic             out_last_next;

  assign status.busy     = char_due || (qcnt != 3'd0) || end_flag;
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    logic       full;
    logic       room2;
    logic       res_en;
    logic [7:0] res_byte;
    logic       res_char;
    logic       vis_req;
    logic [7:0] vis_c;
    logic       ws_req;
    logic [7:0] b;
    logic [7:0] la_new [HOLD_DEPTH];
    logic [2:0] fill_new;
    logic       pref [NUM_ENT];
    logic       hit;
    logic       any_pref;
    logic [7:0] hit_char;
    logic [2:0] idx;

    inside_tag_next = inside_tag;
    space_owed_next = space_owed;
    count_next      = count;
    pending_next    = pending;
    fill_next       = fill;
    qcnt_next       = qcnt;
    end_flag_next   = end_flag;
    char_due_next   = char_due;
    char_hold_next  = char_hold;
    stg_valid_next  = stg_valid;
    stg_byte_next   = stg_byte;
    stg_char_next   = stg_char;
    out_valid_next  = out_valid;
    out_byte_next   = out_byte;
    out_char_next   = out_char;
    out_last_next   = out_last;
    for (int i = 0; i < HOLD_DEPTH; i++) la_next[i] = la[i];
    for (int i = 0; i < QUEUE_DEPTH; i++) q_next[i] = q[i];

    full     = !(({1'b0, count} + 10'd1) < {1'b0, cap});
    room2    = ({1'b0, count} + 10'd2) < {1'b0, cap};
    res_en   = 1'b0;
    res_byte = CHAR_NUL;
    res_char = 1'b0;
    vis_req  = 1'b0;
    vis_c    = CHAR_NUL;
    ws_req   = 1'b0;
    b        = q[0];
    hit      = 1'b0;
    any_pref = 1'b0;
    hit_char = CHAR_NUL;
    idx      = 3'd0;
    fill_new = fill + 3'd1;

    // lookahead with the head byte appended at the fill position
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      la_new[i] = (3'(i) == fill) ? b : la[i];
    end
    for (int e = 0; e < NUM_ENT; e++) begin
      pref[e] = (fill_new <= ENT_LEN[e]);
      for (int j = 0; j < HOLD_DEPTH; j++) begin
        if ((3'(j) < fill_new) && (la_new[j] != ENT_NAME[e][j])) pref[e] = 1'b0;
      end
    end
    for (int e = 0; e < NUM_ENT; e++) begin
      if (pref[e]) any_pref = 1'b1;
      if (!hit && pref[e] && (fill_new == ENT_LEN[e])) begin
        hit      = 1'b1;
        hit_char = ENT_CHAR[e];
      end
    end

    if (cmd.step) begin
      if (char_due) begin
        // second half of a space-then-character pair, room already checked
        res_en        = 1'b1;
        res_byte      = char_hold;
        res_char      = 1'b1;
        count_next    = count + 9'd1;
        char_due_next = 1'b0;
      end else if (qcnt != 3'd0) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) q_next[i] = q[i+1];
        qcnt_next = qcnt - 3'd1;
        if (!full) begin
          if (pending) begin
            if (hit) begin
              pending_next = 1'b0;
              fill_next    = 3'd0;
              if (hit_char == CHAR_NUL) begin
                ws_req = 1'b1;
              end else begin
                vis_req = 1'b1;
                vis_c   = hit_char;
              end
            end else if (any_pref) begin
              for (int i = 0; i < HOLD_DEPTH; i++) la_next[i] = la_new[i];
              fill_next = fill_new;
            end else begin
              // failed entity: held bytes go in front of the rest of the queue
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (3'(i) < fill_new) begin
                  q_next[i] = la_new[i];
                end else begin
                  idx = 3'(i) - fill_new + 3'd1;
                  q_next[i] = (idx < 3'(QUEUE_DEPTH)) ? q[idx] : CHAR_NUL;
                end
              end
              qcnt_next    = fill_new + qcnt - 3'd1;
              pending_next = 1'b0;
              fill_next    = 3'd0;
              vis_req      = 1'b1;
              vis_c        = CHAR_AMP;
            end
          end else if (inside_tag) begin
            if (b == CHAR_GT) inside_tag_next = 1'b0;
          end else if (b == CHAR_LT) begin
            inside_tag_next = 1'b1;
          end else if (b == CHAR_AMP) begin
            pending_next = 1'b1;
            fill_next    = 3'd0;
          end else if (is_space(b)) begin
            ws_req = 1'b1;
          end else begin
            vis_req = 1'b1;
            vis_c   = b;
          end
        end
      end else if (end_flag && pending) begin
        // text ended inside an entity
        for (int i = 0; i < QUEUE_DEPTH; i++) q_next[i] = la[i];
        qcnt_next    = fill;
        pending_next = 1'b0;
        fill_next    = 3'd0;
        vis_req      = 1'b1;
        vis_c        = CHAR_AMP;
      end else if (end_flag) begin
        res_en          = 1'b1;
        res_byte        = CHAR_NUL;
        res_char        = 1'b0;
        end_flag_next   = 1'b0;
        inside_tag_next = 1'b0;
        space_owed_next = 1'b0;
        count_next      = '0;
        pending_next    = 1'b0;
        fill_next       = 3'd0;
      end
    end

    if (ws_req) space_owed_next = (count != '0);
    if (vis_req) begin
      if (space_owed) begin
        if (room2) begin
          res_en          = 1'b1;
          res_byte        = CHAR_SPACE;
          res_char        = 1'b1;
          count_next      = count + 9'd1;
          space_owed_next = 1'b0;
          char_due_next   = 1'b1;
          char_hold_next  = vis_c;
        end
      end else if (!full) begin
        res_en     = 1'b1;
        res_byte   = vis_c;
        res_char   = 1'b1;
        count_next = count + 9'd1;
      end
    end

    if (cmd.load) begin
      q_next[0]     = in_byte;
      qcnt_next     = 3'd1;
      end_flag_next = in_end;
    end

    // staging holds the newest beat until it is known whether another follows
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (res_en) begin
      if (stg_valid) begin
        out_valid_next = 1'b1;
        out_byte_next  = stg_byte;
        out_char_next  = stg_char;
        out_last_next  = 1'b0;
      end
      stg_valid_next = 1'b1;
      stg_byte_next  = res_byte;
      stg_char_next  = res_char;
    end
    if (cmd.flush && stg_valid) begin
      out_valid_next = 1'b1;
      out_byte_next  = stg_byte;
      out_char_next  = stg_char;
      out_last_next  = 1'b1;
      stg_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap        <= CAP_RESET;
      inside_tag <= 1'b0;
      space_owed <= 1'b0;
      count      <= '0;
      pending    <= 1'b0;
      fill       <= 3'd0;
      qcnt       <= 3'd0;
      end_flag   <= 1'b0;
      char_due   <= 1'b0;
      stg_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) cap <= cfg_wr_data;
      inside_tag <= inside_tag_next;
      space_owed <= space_owed_next;
      count      <= count_next;
      pending    <= pending_next;
      fill       <= fill_next;
      qcnt       <= qcnt_next;
      end_flag   <= end_flag_next;
      char_due   <= char_due_next;
      stg_valid  <= stg_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HOLD_DEPTH; i++) la[i] <= la_next[i];
    for (int i = 0; i < QUEUE_DEPTH; i++) q[i] <= q_next[i];
    char_hold <= char_hold_next;
    stg_byte  <= stg_byte_next;
    stg_char  <= stg_char_next;
    out_byte  <= out_byte_next;
    out_char  <= out_char_next;
    out_last  <= out_last_next;
  end

endmodule

>>> hw/rtl/html_inner_text_cleaner.sv
// html_inner_text_cleaner: top level of the streaming tag/entity/whitespace cleaner
// depends on hitc_pkg, hitc_if, hitc_ctrl and hitc_datapath
//
//   channel   dir   beat fields                       notes
//   text      in    text_byte[8], text_end            one raw byte, text_end on last
//   clean     out   clean_byte[8], is_char, run_last  run_last on last beat of an item
//   cfg       in    cfg_wr_en, cfg_wr_data[9]         out_capacity, write-only
//
// a plain byte is loaded and then takes one datapath step; every byte
// in the work queue (input byte or one replayed after a failed entity) costs a
// step, a character behind an emitted space one more, an entity still open at
// text_end one more, the end marker one more
// the last beat of an item sits in the staging register and leaves marked
// run_last in the closing cycle, which can also load the next item
// rst is synchronous, active high; out_capacity resets to 128
// steps wait while the output register holds a beat that is not taken
module html_inner_text_cleaner (
  input  logic                      clk,
  input  logic                      rst,
  hitc_text_if.sink                 text,
  hitc_clean_if.source              clean,
  input  logic                      cfg_wr_en,
  input  logic [hitc_pkg::CAP_W-1:0] cfg_wr_data
);
  import hitc_pkg::*;

  dp_cmd_t    cmd;     // controller to datapath
  dp_status_t status;  // datapath to controller

  // sequencing: load on accept, then one step per cycle unless stalled, then close
  hitc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text.valid),
    .in_ready (text.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // queue, lookahead, text state and the output register feeding clean
  hitc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_byte     (text.text_byte),
    .in_end      (text.text_end),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (clean.ready),
    .out_valid   (clean.valid),
    .out_byte    (clean.clean_byte),
    .out_char    (clean.is_char),
    .out_last    (clean.run_last)
  );

endmodule
